// ----- src/eps_pkg.sv -----
`default_nettype none

package eps_pkg;

    localparam int QUEUE_DEPTH         = 4;
    localparam int MAX_ELEMENTS        = 16;
    localparam int MAX_EVENTS_PER_TICK = 64;

    localparam int QIDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QSIZE_W = $clog2(QUEUE_DEPTH + 1);
    localparam int EI_W    = $clog2(MAX_ELEMENTS + 1);
    localparam int TIDX_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int NCNT_W  = $clog2(MAX_EVENTS_PER_TICK + 1);

    localparam int OP_W    = 3;
    localparam int CNT_W   = 32;
    localparam int MM_W    = 24;
    localparam int RATIO_W = 32;
    localparam int DOT_W   = 16;
    localparam int LATE_W  = 31;
    localparam int KIND_W  = 3;
    localparam int IDX_W   = 4;
    localparam int PAT_W   = 2;
    localparam int ECNT_W  = 5;
    localparam int PROD_W  = 56;
    localparam int POS_W   = 41;
    localparam int FRAC_W  = 24;
    localparam int DVD_W   = 56;
    localparam int DCNT_W  = 6;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [RATIO_W-1:0] RATIO_RESET  = 32'd808714;
    localparam logic [MM_W-1:0]    OFFSET_RESET = 24'd64000;
    localparam logic [PROD_W-1:0]  ROUND_HALF   = 56'h800000;
    localparam logic [DCNT_W-1:0]  DIV_STEPS_M1 = 6'd55;

    localparam logic [PAT_W-1:0] PAT_NONE  = 2'd0;
    localparam logic [PAT_W-1:0] PAT_LINES = 2'd1;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 3'd0,
        OP_LEAD  = 3'd1,
        OP_TRAIL = 3'd2,
        OP_ARM   = 3'd3,
        OP_ABORT = 3'd4,
        OP_LOAD  = 3'd5
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_DOT   = 3'd0,
        KIND_OPEN  = 3'd1,
        KIND_CLOSE = 3'd2,
        KIND_CAL   = 3'd3,
        KIND_OVF   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        CAL_IDLE  = 2'd0,
        CAL_LEAD  = 2'd1,
        CAL_TRAIL = 2'd2
    } cal_phase_t;

    typedef enum logic [1:0] {
        REG_PATTERN = 2'd0,
        REG_ECOUNT  = 2'd1,
        REG_PPM     = 2'd2,
        REG_OFFSET  = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        MUL_OFFSET,
        MUL_DOT,
        MUL_DOT_NEXT,
        MUL_POS
    } mul_sel_t;

    typedef enum logic [1:0] {
        PEND_EVENT,
        PEND_OVF,
        PEND_CAL
    } pend_src_t;

    typedef struct packed {
        logic [PAT_W-1:0]   pattern;
        logic [ECNT_W-1:0]  elem_count;
        logic [RATIO_W-1:0] ppm;
        logic [MM_W-1:0]    offset;
    } cfg_t;

    typedef struct packed {
        logic      take;
        logic      mul_en;
        mul_sel_t  mul_sel;
        logic      off_set;
        logic      pos_line;
        logic      pos_dot;
        logic      due_calc;
        logic      pend_load;
        pend_src_t pend_src;
        logic      push_last;
        logic      n_clear;
        logic      adv_line;
        logic      adv_dot;
        logic      retire;
        logic      enq;
        logic      cal_cap;
        logic      cal_arm;
        logic      cal_end;
        logic      abort;
        logic      load;
        logic      div_start;
        logic      div_step;
        logic      cal_set;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            running;
        logic            fault;
        cal_phase_t      cal_phase;
        logic            len_zero;
        logic            q_empty;
        logic            q_full;
        logic            n_max;
        logic            head_skip;
        logic            lines;
        logic            pos_over;
        logic            late_neg;
        logic            pend_v;
        logic            out_busy;
        logic            div_last;
    } stat_t;

endpackage

`default_nettype wire

// ----- src/eps_item_if.sv -----
`default_nettype none

interface eps_item_if;
    logic                         valid;
    logic                         ready;
    logic [eps_pkg::OP_W-1:0]     op;
    logic [eps_pkg::CNT_W-1:0]    pulse_count;
    logic                         running;
    logic                         fault;
    logic                         too_slow;
    logic [eps_pkg::MM_W-1:0]     paper_length_mm;
    logic [eps_pkg::IDX_W-1:0]    elem_index;
    logic [eps_pkg::MM_W-1:0]     elem_start_mm;
    logic [eps_pkg::MM_W-1:0]     elem_end_mm;
    logic [eps_pkg::MM_W-1:0]     elem_spacing_mm;

    modport source (
        output valid, op, pulse_count, running, fault, too_slow, paper_length_mm,
               elem_index, elem_start_mm, elem_end_mm, elem_spacing_mm,
        input  ready
    );
    modport sink (
        input  valid, op, pulse_count, running, fault, too_slow, paper_length_mm,
               elem_index, elem_start_mm, elem_end_mm, elem_spacing_mm,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/eps_result_if.sv -----
`default_nettype none

interface eps_result_if;
    logic                          valid;
    logic                          ready;
    logic [eps_pkg::KIND_W-1:0]    kind;
    logic                          fire;
    logic [eps_pkg::LATE_W-1:0]    late_pulses;
    logic [eps_pkg::RATIO_W-1:0]   calib_ratio;
    logic                          last;

    modport source (
        output valid, kind, fire, late_pulses, calib_ratio, last,
        input  ready
    );
    modport sink (
        input  valid, kind, fire, late_pulses, calib_ratio, last,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/eps_regs.sv -----
`default_nettype none

module eps_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [eps_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [eps_pkg::DATA_W-1:0]  pwdata,
    output logic      [eps_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output eps_pkg::cfg_t                    cfg,
    output logic                             ppm_wr
);

    eps_pkg::cfg_t cfg_reg;
    logic          ppm_wr_reg;
    logic          wr_en;
    logic [1:0]    idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign ppm_wr = ppm_wr_reg;
    assign cfg    = cfg_reg;

    // The working ratio is loaded in the cycle after the write, once the register holds it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern    <= eps_pkg::PAT_NONE;
            cfg_reg.elem_count <= '0;
            cfg_reg.ppm        <= eps_pkg::RATIO_RESET;
            cfg_reg.offset     <= eps_pkg::OFFSET_RESET;
            ppm_wr_reg         <= 1'b0;
        end
        else
        begin
            ppm_wr_reg <= wr_en && (idx == eps_pkg::REG_PPM);
            if (wr_en)
            begin
                case (idx)
                    eps_pkg::REG_PATTERN: cfg_reg.pattern    <= pwdata[eps_pkg::PAT_W-1:0];
                    eps_pkg::REG_ECOUNT:  cfg_reg.elem_count <= pwdata[eps_pkg::ECNT_W-1:0];
                    eps_pkg::REG_PPM:     cfg_reg.ppm        <= pwdata;
                    eps_pkg::REG_OFFSET:  cfg_reg.offset     <= pwdata[eps_pkg::MM_W-1:0];
                    default:              cfg_reg.offset     <= cfg_reg.offset;
                endcase
            end
        end
    end

    always_comb
    begin
        case (idx)
            eps_pkg::REG_PATTERN: prdata = 32'(cfg_reg.pattern);
            eps_pkg::REG_ECOUNT:  prdata = 32'(cfg_reg.elem_count);
            eps_pkg::REG_PPM:     prdata = cfg_reg.ppm;
            eps_pkg::REG_OFFSET:  prdata = 32'(cfg_reg.offset);
            default:              prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/eps_ctrl.sv -----
`default_nettype none

module eps_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_ready,
    input  wire eps_pkg::stat_t st,
    output eps_pkg::cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_OFFR,
        S_CHK,
        S_CMP,
        S_MUL,
        S_DUE,
        S_EMIT,
        S_ACMP,
        S_DIV,
        S_CALOUT,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign item_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                case (st.op)
                    eps_pkg::OP_TICK:
                    begin
                        if (st.running)
                        begin
                            cmd.n_clear = 1'b1;
                            cmd.mul_en  = 1'b1;
                            cmd.mul_sel = eps_pkg::MUL_OFFSET;
                            state_next  = S_OFFR;
                        end
                    end
                    eps_pkg::OP_LEAD:
                    begin
                        if (st.cal_phase == eps_pkg::CAL_LEAD)
                        begin
                            cmd.cal_cap = 1'b1;
                        end
                        else if (st.running && !st.fault)
                        begin
                            if (st.q_full)
                            begin
                                cmd.pend_load = 1'b1;
                                cmd.pend_src  = eps_pkg::PEND_OVF;
                                state_next    = S_FINISH;
                            end
                            else
                            begin
                                cmd.enq = 1'b1;
                            end
                        end
                    end
                    eps_pkg::OP_TRAIL:
                    begin
                        if (st.cal_phase == eps_pkg::CAL_TRAIL)
                        begin
                            cmd.cal_end = 1'b1;
                            if (!st.len_zero)
                            begin
                                cmd.div_start = 1'b1;
                                state_next    = S_DIV;
                            end
                        end
                    end
                    eps_pkg::OP_ARM:   cmd.cal_arm = 1'b1;
                    eps_pkg::OP_ABORT: cmd.abort   = 1'b1;
                    eps_pkg::OP_LOAD:  cmd.load    = 1'b1;
                    default:           state_next  = S_IDLE;
                endcase
            end
            S_OFFR:
            begin
                cmd.off_set = 1'b1;
                state_next  = S_CHK;
            end
            S_CHK:
            begin
                if (st.q_empty || st.n_max)
                begin
                    state_next = S_FINISH;
                end
                else if (st.head_skip)
                begin
                    cmd.retire = 1'b1;
                end
                else if (st.lines)
                begin
                    cmd.pos_line = 1'b1;
                    state_next   = S_MUL;
                end
                else
                begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = eps_pkg::MUL_DOT;
                    state_next  = S_CMP;
                end
            end
            S_CMP:
            begin
                // A first dot past the element end retires the whole sheet.
                if (st.pos_over)
                begin
                    cmd.retire = 1'b1;
                    state_next = S_CHK;
                end
                else
                begin
                    cmd.pos_dot = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = eps_pkg::MUL_POS;
                state_next  = S_DUE;
            end
            S_DUE:
            begin
                cmd.due_calc = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (st.late_neg)
                begin
                    state_next = S_FINISH;
                end
                else if (!(st.pend_v && st.out_busy))
                begin
                    cmd.pend_load = 1'b1;
                    cmd.pend_src  = eps_pkg::PEND_EVENT;
                    if (st.lines)
                    begin
                        cmd.adv_line = 1'b1;
                        state_next   = S_CHK;
                    end
                    else
                    begin
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = eps_pkg::MUL_DOT_NEXT;
                        state_next  = S_ACMP;
                    end
                end
            end
            S_ACMP:
            begin
                cmd.adv_dot = 1'b1;
                state_next  = S_CHK;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                begin
                    state_next = S_CALOUT;
                end
            end
            S_CALOUT:
            begin
                cmd.pend_load = 1'b1;
                cmd.pend_src  = eps_pkg::PEND_CAL;
                cmd.cal_set   = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                if (!(st.pend_v && st.out_busy))
                begin
                    cmd.push_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/eps_datapath.sv -----
`default_nettype none

module eps_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire eps_pkg::cmd_t                 cmd,
    output eps_pkg::stat_t                     st,
    input  wire eps_pkg::cfg_t                 cfg,
    input  wire logic                          ppm_wr,
    input  wire logic [eps_pkg::OP_W-1:0]      op,
    input  wire logic [eps_pkg::CNT_W-1:0]     pulse_count,
    input  wire logic                          running,
    input  wire logic                          fault,
    input  wire logic                          too_slow,
    input  wire logic [eps_pkg::MM_W-1:0]      paper_length_mm,
    input  wire logic [eps_pkg::IDX_W-1:0]     elem_index,
    input  wire logic [eps_pkg::MM_W-1:0]      elem_start_mm,
    input  wire logic [eps_pkg::MM_W-1:0]      elem_end_mm,
    input  wire logic [eps_pkg::MM_W-1:0]      elem_spacing_mm,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [eps_pkg::KIND_W-1:0]         kind,
    output logic                               fire,
    output logic [eps_pkg::LATE_W-1:0]         late_pulses,
    output logic [eps_pkg::RATIO_W-1:0]        calib_ratio,
    output logic                               last
);

    localparam int D = eps_pkg::QUEUE_DEPTH;
    localparam int M = eps_pkg::MAX_ELEMENTS;

    // Latched request
    logic [eps_pkg::OP_W-1:0]    op_reg;
    logic [eps_pkg::CNT_W-1:0]   cnt_reg;
    logic                        run_reg;
    logic                        fault_reg;
    logic                        slow_reg;
    logic [eps_pkg::MM_W-1:0]    len_in_reg;
    logic [eps_pkg::IDX_W-1:0]   idx_reg;
    logic [eps_pkg::MM_W-1:0]    start_in_reg;
    logic [eps_pkg::MM_W-1:0]    end_in_reg;
    logic [eps_pkg::MM_W-1:0]    sp_in_reg;

    // Sheet ring and element table
    logic [eps_pkg::CNT_W-1:0]   edge_reg [D];
    logic [eps_pkg::EI_W-1:0]    elem_reg [D];
    logic [eps_pkg::DOT_W-1:0]   dot_reg  [D];
    logic                        open_reg [D];
    logic [eps_pkg::QIDX_W-1:0]  head_reg;
    logic [eps_pkg::QSIZE_W-1:0] size_reg;
    logic [eps_pkg::MM_W-1:0]    tstart_reg [M];
    logic [eps_pkg::MM_W-1:0]    tend_reg   [M];
    logic [eps_pkg::MM_W-1:0]    tsp_reg    [M];

    // Calibration and ratio
    eps_pkg::cal_phase_t         cal_phase_reg;
    logic [eps_pkg::CNT_W-1:0]   cal_lead_reg;
    logic [eps_pkg::MM_W-1:0]    cal_len_reg;
    logic [eps_pkg::RATIO_W-1:0] wr_reg;

    // Event arithmetic
    logic [eps_pkg::CNT_W-1:0]   offp_reg;
    logic [eps_pkg::MM_W-1:0]    pos_reg;
    logic [eps_pkg::PROD_W-1:0]  prod_reg;
    logic [eps_pkg::CNT_W-1:0]   late_reg;
    logic [eps_pkg::NCNT_W-1:0]  n_reg;

    // Pending result, held until the next one shows whether it is the last
    logic                        pend_v_reg;
    logic [eps_pkg::KIND_W-1:0]  pend_kind_reg;
    logic                        pend_fire_reg;
    logic [eps_pkg::LATE_W-1:0]  pend_late_reg;
    logic [eps_pkg::RATIO_W-1:0] pend_ratio_reg;

    logic                        out_valid_reg;
    logic [eps_pkg::KIND_W-1:0]  out_kind_reg;
    logic                        out_fire_reg;
    logic [eps_pkg::LATE_W-1:0]  out_late_reg;
    logic [eps_pkg::RATIO_W-1:0] out_ratio_reg;
    logic                        out_last_reg;

    // Divider
    logic [eps_pkg::MM_W-1:0]    rem_reg;
    logic [eps_pkg::DVD_W-1:0]   dvd_reg;
    logic [eps_pkg::RATIO_W-1:0] quo_reg;
    logic                        ovf_reg;
    logic [eps_pkg::DCNT_W-1:0]  dcnt_reg;

    logic [eps_pkg::EI_W-1:0]    h_elem;
    logic [eps_pkg::DOT_W-1:0]   h_dot;
    logic                        h_open;
    logic [eps_pkg::TIDX_W-1:0]  tidx;
    logic [eps_pkg::MM_W-1:0]    e_start;
    logic [eps_pkg::MM_W-1:0]    e_end;
    logic [eps_pkg::MM_W-1:0]    e_sp;
    logic                        lines;
    logic [eps_pkg::MM_W-1:0]    mul_a;
    logic [eps_pkg::RATIO_W-1:0] mul_b;
    logic [eps_pkg::PROD_W-1:0]  prod_rnd;
    logic [eps_pkg::CNT_W-1:0]   pulses;
    logic [eps_pkg::POS_W-1:0]   pos_sum;
    logic                        pos_over;
    logic [eps_pkg::QIDX_W-1:0]  head_inc;
    logic [eps_pkg::QSIZE_W:0]   tail_sum;
    logic [eps_pkg::QIDX_W-1:0]  tail;
    logic [eps_pkg::MM_W:0]      r_sh;
    logic                        q_bit;
    logic [eps_pkg::RATIO_W-1:0] div_ratio;
    logic [eps_pkg::CNT_W-1:0]   cal_diff;
    logic                        push;
    logic                        push_last_bit;

    assign h_elem  = elem_reg[head_reg];
    assign h_dot   = dot_reg[head_reg];
    assign h_open  = open_reg[head_reg];
    assign tidx    = eps_pkg::TIDX_W'(h_elem);
    assign e_start = tstart_reg[tidx];
    assign e_end   = tend_reg[tidx];
    assign e_sp    = tsp_reg[tidx];
    assign lines   = (cfg.pattern == eps_pkg::PAT_LINES);

    always_comb
    begin
        case (cmd.mul_sel)
            eps_pkg::MUL_OFFSET:
            begin
                mul_a = cfg.offset;
                mul_b = wr_reg;
            end
            eps_pkg::MUL_DOT:
            begin
                mul_a = e_sp;
                mul_b = 32'(h_dot);
            end
            eps_pkg::MUL_DOT_NEXT:
            begin
                mul_a = e_sp;
                mul_b = 32'(eps_pkg::DOT_W'(h_dot + 16'd1));
            end
            default:
            begin
                mul_a = pos_reg;
                mul_b = wr_reg;
            end
        endcase
    end

    // Q16.8 by Q16.16 gives 24 fraction bits; round half up to whole pulses.
    assign prod_rnd = prod_reg + eps_pkg::ROUND_HALF;
    assign pulses   = prod_rnd[eps_pkg::FRAC_W +: eps_pkg::CNT_W];
    assign pos_sum  = eps_pkg::POS_W'(e_start) + prod_reg[eps_pkg::POS_W-2:0];
    assign pos_over = pos_sum > eps_pkg::POS_W'(e_end);

    assign head_inc = (32'(head_reg) == D - 1) ? '0 : eps_pkg::QIDX_W'(head_reg + 1'b1);
    assign tail_sum = (eps_pkg::QSIZE_W + 1)'(head_reg) + (eps_pkg::QSIZE_W + 1)'(size_reg);
    assign tail     = (32'(tail_sum) >= D) ? eps_pkg::QIDX_W'(32'(tail_sum) - D)
                                           : eps_pkg::QIDX_W'(tail_sum);

    assign r_sh      = {rem_reg, dvd_reg[eps_pkg::DVD_W-1]};
    assign q_bit     = r_sh >= {1'b0, cal_len_reg};
    assign div_ratio = ovf_reg ? '1 : quo_reg;
    assign cal_diff  = cnt_reg - cal_lead_reg;

    assign push          = (cmd.pend_load || cmd.push_last) && pend_v_reg;
    assign push_last_bit = cmd.push_last;

    always_comb
    begin
        st           = '0;
        st.op        = op_reg;
        st.running   = run_reg;
        st.fault     = fault_reg;
        st.cal_phase = cal_phase_reg;
        st.len_zero  = (cal_len_reg == '0);
        st.q_empty   = (size_reg == '0);
        st.q_full    = (32'(size_reg) >= D);
        st.n_max     = (32'(n_reg) == eps_pkg::MAX_EVENTS_PER_TICK);
        st.head_skip = (cfg.pattern == eps_pkg::PAT_NONE)
                       || (32'(h_elem) >= 32'(cfg.elem_count))
                       || (32'(h_elem) >= M);
        st.lines     = lines;
        st.pos_over  = pos_over;
        st.late_neg  = late_reg[eps_pkg::CNT_W-1];
        st.pend_v    = pend_v_reg;
        st.out_busy  = out_valid_reg && !out_ready;
        st.div_last  = (dcnt_reg == '0);
    end

    // Request and arithmetic registers (no reset needed)
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg       <= op;
            cnt_reg      <= pulse_count;
            run_reg      <= running;
            fault_reg    <= fault;
            slow_reg     <= too_slow;
            len_in_reg   <= paper_length_mm;
            idx_reg      <= elem_index;
            start_in_reg <= elem_start_mm;
            end_in_reg   <= elem_end_mm;
            sp_in_reg    <= elem_spacing_mm;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= eps_pkg::PROD_W'(mul_a) * eps_pkg::PROD_W'(mul_b);
        end
        if (cmd.off_set)
        begin
            offp_reg <= pulses;
        end
        if (cmd.pos_line)
        begin
            pos_reg <= h_open ? e_end : e_start;
        end
        if (cmd.pos_dot)
        begin
            pos_reg <= pos_sum[eps_pkg::MM_W-1:0];
        end
        if (cmd.due_calc)
        begin
            late_reg <= cnt_reg - (edge_reg[head_reg] + offp_reg + pulses);
        end
        if (cmd.enq)
        begin
            edge_reg[tail] <= cnt_reg;
            elem_reg[tail] <= '0;
            dot_reg[tail]  <= '0;
            open_reg[tail] <= 1'b0;
        end
        if (cmd.adv_line)
        begin
            open_reg[head_reg] <= !h_open;
            if (h_open)
            begin
                elem_reg[head_reg] <= eps_pkg::EI_W'(h_elem + 1'b1);
            end
        end
        if (cmd.adv_dot)
        begin
            if (pos_over)
            begin
                dot_reg[head_reg]  <= '0;
                elem_reg[head_reg] <= eps_pkg::EI_W'(h_elem + 1'b1);
            end
            else
            begin
                dot_reg[head_reg] <= eps_pkg::DOT_W'(h_dot + 16'd1);
            end
        end
        if (cmd.load && (32'(idx_reg) < M))
        begin
            tstart_reg[eps_pkg::TIDX_W'(idx_reg)] <= start_in_reg;
            tend_reg[eps_pkg::TIDX_W'(idx_reg)]   <= end_in_reg;
            tsp_reg[eps_pkg::TIDX_W'(idx_reg)]    <= sp_in_reg;
        end
        if (cmd.div_start)
        begin
            dvd_reg  <= (eps_pkg::DVD_W'(cal_diff) << eps_pkg::FRAC_W)
                        + eps_pkg::DVD_W'(cal_len_reg >> 1);
            rem_reg  <= '0;
            quo_reg  <= '0;
            ovf_reg  <= 1'b0;
            dcnt_reg <= eps_pkg::DIV_STEPS_M1;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= q_bit ? eps_pkg::MM_W'(r_sh - {1'b0, cal_len_reg})
                              : r_sh[eps_pkg::MM_W-1:0];
            dvd_reg  <= dvd_reg << 1;
            quo_reg  <= {quo_reg[eps_pkg::RATIO_W-2:0], q_bit};
            ovf_reg  <= ovf_reg || quo_reg[eps_pkg::RATIO_W-1];
            dcnt_reg <= dcnt_reg - 1'b1;
        end
        if (cmd.pend_load)
        begin
            case (cmd.pend_src)
                eps_pkg::PEND_EVENT:
                begin
                    pend_kind_reg  <= !lines ? eps_pkg::KIND_DOT
                                    : (h_open ? eps_pkg::KIND_CLOSE : eps_pkg::KIND_OPEN);
                    pend_fire_reg  <= !slow_reg;
                    pend_late_reg  <= late_reg[eps_pkg::LATE_W-1:0];
                    pend_ratio_reg <= '0;
                end
                eps_pkg::PEND_CAL:
                begin
                    pend_kind_reg  <= eps_pkg::KIND_CAL;
                    pend_fire_reg  <= 1'b0;
                    pend_late_reg  <= '0;
                    pend_ratio_reg <= div_ratio;
                end
                default:
                begin
                    pend_kind_reg  <= eps_pkg::KIND_OVF;
                    pend_fire_reg  <= 1'b0;
                    pend_late_reg  <= '0;
                    pend_ratio_reg <= '0;
                end
            endcase
        end
        if (push)
        begin
            out_kind_reg  <= pend_kind_reg;
            out_fire_reg  <= pend_fire_reg;
            out_late_reg  <= pend_late_reg;
            out_ratio_reg <= pend_ratio_reg;
            out_last_reg  <= push_last_bit;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            size_reg      <= '0;
            cal_phase_reg <= eps_pkg::CAL_IDLE;
            cal_lead_reg  <= '0;
            cal_len_reg   <= '0;
            wr_reg        <= eps_pkg::RATIO_RESET;
            n_reg         <= '0;
            pend_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.abort)
            begin
                head_reg <= '0;
                size_reg <= '0;
            end
            else if (cmd.retire)
            begin
                head_reg <= head_inc;
                size_reg <= size_reg - 1'b1;
            end
            else if (cmd.enq)
            begin
                size_reg <= size_reg + 1'b1;
            end

            if (cmd.cal_cap)
            begin
                cal_lead_reg  <= cnt_reg;
                cal_phase_reg <= eps_pkg::CAL_TRAIL;
            end
            else if (cmd.cal_arm)
            begin
                cal_len_reg   <= len_in_reg;
                cal_phase_reg <= eps_pkg::CAL_LEAD;
            end
            else if (cmd.cal_end)
            begin
                cal_phase_reg <= eps_pkg::CAL_IDLE;
            end

            if (ppm_wr)
            begin
                wr_reg <= cfg.ppm;
            end
            else if (cmd.cal_set)
            begin
                wr_reg <= div_ratio;
            end

            if (cmd.n_clear)
            begin
                n_reg <= '0;
            end
            else if (cmd.pend_load && (cmd.pend_src == eps_pkg::PEND_EVENT))
            begin
                n_reg <= n_reg + 1'b1;
            end

            if (cmd.pend_load)
            begin
                pend_v_reg <= 1'b1;
            end
            else if (cmd.push_last)
            begin
                pend_v_reg <= 1'b0;
            end

            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = out_kind_reg;
    assign fire        = out_fire_reg;
    assign late_pulses = out_late_reg;
    assign calib_ratio = out_ratio_reg;
    assign last        = out_last_reg;

    // The ring never holds more sheets than it has room for.
    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(size_reg) <= D)
        else $error("sheet ring overfilled");

    // A result is never written over one that is still waiting to be taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (push && out_valid_reg) |-> out_ready)
        else $error("result register overwritten");

    // One tick never emits more than the event limit.
    a_event_cap: assert property (@(posedge clk) disable iff (!rst_n)
        32'(n_reg) <= eps_pkg::MAX_EVENTS_PER_TICK)
        else $error("event count beyond limit");

    // The working ratio moves only by a register write or a calibration.
    a_ratio_src: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(wr_reg) |-> ($past(ppm_wr) || $past(cmd.cal_set)))
        else $error("working ratio changed without cause");

endmodule

`default_nettype wire

// ----- src/encoder_pattern_event_scheduler.sv -----
// Channel   Role    Handshake      Carries
// item      sink    valid/ready    op, pulse_count, flags, calibration and element fields
// result    source  valid/ready    kind, fire, late_pulses, calib_ratio, last
// APB       slave   psel/penable   pattern_type, element_count, encoder ratio, offset_mm
//
// One request is handled at a time. A tick's dot and line events are worked out by the
// shared 24x32 multiplier, which serves offset, dot position and pulse conversion in turn.
// A calibration result is worked out by the 56-step restoring divider.
// Reset is asynchronous and leaves the queue empty; sheet and element stores are
// not cleared. A stalled result register holds the controller, so the next request waits.
`default_nettype none

module encoder_pattern_event_scheduler (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    eps_item_if.sink                         item,
    eps_result_if.source                     result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [eps_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [eps_pkg::DATA_W-1:0]  pwdata,
    output logic      [eps_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);

    eps_pkg::cfg_t  cfg;
    eps_pkg::cmd_t  cmd;
    eps_pkg::stat_t st;
    logic           ppm_wr;

    eps_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .ppm_wr  (ppm_wr)
    );

    eps_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .st         (st),
        .cmd        (cmd)
    );

    eps_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .cfg             (cfg),
        .ppm_wr          (ppm_wr),
        .op              (item.op),
        .pulse_count     (item.pulse_count),
        .running         (item.running),
        .fault           (item.fault),
        .too_slow        (item.too_slow),
        .paper_length_mm (item.paper_length_mm),
        .elem_index      (item.elem_index),
        .elem_start_mm   (item.elem_start_mm),
        .elem_end_mm     (item.elem_end_mm),
        .elem_spacing_mm (item.elem_spacing_mm),
        .out_valid       (result.valid),
        .out_ready       (result.ready),
        .kind            (result.kind),
        .fire            (result.fire),
        .late_pulses     (result.late_pulses),
        .calib_ratio     (result.calib_ratio),
        .last            (result.last)
    );

endmodule

`default_nettype wire

// ----- sim/tb_encoder_pattern_event_scheduler.sv -----
`timescale 1ns / 1ps

module tb_encoder_pattern_event_scheduler;
    import eps_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
    localparam logic [23:0]     MM_MAX      = 24'hFFFFFF;
    localparam int              SETTLE      = 600;

    typedef struct {
        logic [OP_W-1:0] op;
        logic [31:0]     cnt;
        logic            run;
        logic            flt;
        logic            slow;
        logic [23:0]     plen;
        logic [3:0]      idx;
        logic [23:0]     st;
        logic [23:0]     en;
        logic [23:0]     sp;
    } request_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic              fire;
        logic [30:0]       late;
        logic [31:0]       ratio;
        logic              last;
    } event_t;

    class schedule_board;
        logic [31:0] edge_cnt [QUEUE_DEPTH];
        logic [4:0]  elem_no  [QUEUE_DEPTH];
        logic [15:0] dot_no   [QUEUE_DEPTH];
        logic        line_up  [QUEUE_DEPTH];
        int          qhead;
        int          qsize;
        logic [23:0] el_start [MAX_ELEMENTS];
        logic [23:0] el_end   [MAX_ELEMENTS];
        logic [23:0] el_space [MAX_ELEMENTS];
        cal_phase_t  cal_state;
        logic [31:0] cal_lead;
        logic [23:0] cal_len;
        logic [31:0] ratio_now;
        logic [1:0]  pattern;
        logic [4:0]  ecount;
        logic [23:0] offset;
        event_t      due_q[$];
        int          errors;

        function new();
            qhead = 0;
            qsize = 0;
            cal_state = CAL_IDLE;
            cal_lead = 0;
            cal_len = 0;
            pattern = PAT_NONE;
            ecount = 0;
            offset = OFFSET_RESET;
            ratio_now = RATIO_RESET;
            errors = 0;
        endfunction

        function void write_reg(reg_idx_t r, logic [31:0] v);
            case (r)
                REG_PATTERN: pattern = v[1:0];
                REG_ECOUNT:  ecount = v[4:0];
                REG_PPM:     ratio_now = v;
                REG_OFFSET:  offset = v[23:0];
                default:     ;
            endcase
        endfunction

        function logic [31:0] to_pulses(logic [63:0] mm);
            logic [63:0] p;
            p = mm * {32'd0, ratio_now} + 64'h800000;
            return p[55:24];
        endfunction

        function int in_use();
            return (ecount > MAX_ELEMENTS) ? MAX_ELEMENTS : ecount;
        endfunction

        function logic [63:0] dot_pos(int ei, logic [15:0] k);
            return {40'd0, el_start[ei]} + {48'd0, k} * {40'd0, el_space[ei]};
        endfunction

        function bit next_event(int q, output logic [31:0] due, output logic [2:0] act);
            int ei;
            logic [31:0] base;
            logic [63:0] pos;
            ei = elem_no[q];
            due = 0;
            act = KIND_DOT;
            if (ei >= in_use() || pattern == PAT_NONE)
                return 0;
            base = edge_cnt[q] + to_pulses({40'd0, offset});
            if (pattern == PAT_LINES)
            begin
                if (!line_up[q])
                begin
                    due = base + to_pulses({40'd0, el_start[ei]});
                    act = KIND_OPEN;
                end
                else
                begin
                    due = base + to_pulses({40'd0, el_end[ei]});
                    act = KIND_CLOSE;
                end
                return 1;
            end
            pos = dot_pos(ei, dot_no[q]);
            if (pos > {40'd0, el_end[ei]})
                return 0;
            due = base + to_pulses(pos);
            return 1;
        endfunction

        function void advance(int q, logic [2:0] act);
            int ei;
            ei = elem_no[q];
            if (pattern == PAT_LINES)
            begin
                if (act == KIND_OPEN)
                    line_up[q] = 1;
                else
                begin
                    line_up[q] = 0;
                    elem_no[q] = 5'(ei + 1);
                end
            end
            else
            begin
                dot_no[q] = dot_no[q] + 16'd1;
                if (dot_pos(ei, dot_no[q]) > {40'd0, el_end[ei]})
                begin
                    dot_no[q] = 0;
                    elem_no[q] = 5'(ei + 1);
                end
            end
        endfunction

        function void push(logic [2:0] kind, logic fire, logic [30:0] late, logic [31:0] ratio);
            event_t e;
            e.kind = kind;
            e.fire = fire;
            e.late = late;
            e.ratio = ratio;
            e.last = 0;
            due_q.push_back(e);
        endfunction

        function void note_request(request_t r);
            int first;
            int n;
            int q;
            logic [31:0] due;
            logic [31:0] late;
            logic [2:0] act;
            logic [63:0] diff;
            logic [63:0] quo;
            event_t t;
            first = due_q.size();
            n = 0;
            case (r.op)
                OP_TICK:
                begin
                    if (r.run)
                    begin
                        while (qsize > 0 && n < MAX_EVENTS_PER_TICK)
                        begin
                            q = qhead;
                            if (!next_event(q, due, act))
                            begin
                                qhead = (qhead + 1) % QUEUE_DEPTH;
                                qsize--;
                                continue;
                            end
                            late = r.cnt - due;
                            if (late[31])
                                break;
                            push(act, !r.slow, late[30:0], 0);
                            n++;
                            advance(q, act);
                        end
                    end
                end
                OP_LEAD:
                begin
                    if (cal_state == CAL_LEAD)
                    begin
                        cal_lead = r.cnt;
                        cal_state = CAL_TRAIL;
                    end
                    else if (r.run && !r.flt)
                    begin
                        if (qsize >= QUEUE_DEPTH)
                            push(KIND_OVF, 0, 0, 0);
                        else
                        begin
                            q = (qhead + qsize) % QUEUE_DEPTH;
                            edge_cnt[q] = r.cnt;
                            elem_no[q] = 0;
                            dot_no[q] = 0;
                            line_up[q] = 0;
                            qsize++;
                        end
                    end
                end
                OP_TRAIL:
                begin
                    if (cal_state == CAL_TRAIL)
                    begin
                        cal_state = CAL_IDLE;
                        if (cal_len != 0)
                        begin
                            diff = {32'd0, r.cnt - cal_lead};
                            quo = ((diff << 24) + {41'd0, cal_len[23:1]}) / {40'd0, cal_len};
                            ratio_now = (quo > 64'hFFFFFFFF) ? 32'hFFFFFFFF : quo[31:0];
                            push(KIND_CAL, 0, 0, ratio_now);
                        end
                    end
                end
                OP_ARM:
                begin
                    cal_len = r.plen;
                    cal_state = CAL_LEAD;
                end
                OP_ABORT:
                begin
                    qhead = 0;
                    qsize = 0;
                end
                OP_LOAD:
                begin
                    el_start[r.idx] = r.st;
                    el_end[r.idx] = r.en;
                    el_space[r.idx] = r.sp;
                end
                default: ;
            endcase
            if (due_q.size() > first)
            begin
                t = due_q[due_q.size() - 1];
                t.last = 1;
                due_q[due_q.size() - 1] = t;
            end
        endfunction

        function void check(event_t got);
            event_t w;
            if (due_q.size() == 0)
            begin
                $error("result with no expectation: kind %0d", got.kind);
                errors++;
                return;
            end
            w = due_q.pop_front();
            if (got.kind !== w.kind)
            begin
                $error("kind expected %0d got %0d", w.kind, got.kind);
                errors++;
            end
            if (got.fire !== w.fire)
            begin
                $error("fire expected %0d got %0d", w.fire, got.fire);
                errors++;
            end
            if (got.late !== w.late)
            begin
                $error("late_pulses expected %0d got %0d", w.late, got.late);
                errors++;
            end
            if (got.ratio !== w.ratio)
            begin
                $error("calib_ratio expected %0d got %0d", w.ratio, got.ratio);
                errors++;
            end
            if (got.last !== w.last)
            begin
                $error("last expected %0d got %0d", w.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    eps_item_if   itm();
    eps_result_if res();

    encoder_pattern_event_scheduler u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (itm),
        .result  (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    schedule_board sb;
    int            gap_pct;
    int            stall_pct;
    int            hold_off;
    logic [31:0]   enc_now;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("FAIL encoder_pattern_event_scheduler");
        $finish;
    end

    // Result side: checks every accepted result and stalls at random or while held off.
    initial
    begin
        res.ready = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res.valid && res.ready)
                sb.check('{res.kind, res.fire, res.late_pulses, res.calib_ratio, res.last});
            if (hold_off > 0)
            begin
                hold_off--;
                res.ready <= 0;
            end
            else
                res.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic apb_write(reg_idx_t r, logic [31:0] v);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        sb.write_reg(r, v);
        psel <= 0;
        penable <= 0;
    endtask

    task automatic send(request_t r);
        int gap;
        gap = 0;
        itm.valid <= 1;
        itm.op <= r.op;
        itm.pulse_count <= r.cnt;
        itm.running <= r.run;
        itm.fault <= r.flt;
        itm.too_slow <= r.slow;
        itm.paper_length_mm <= r.plen;
        itm.elem_index <= r.idx;
        itm.elem_start_mm <= r.st;
        itm.elem_end_mm <= r.en;
        itm.elem_spacing_mm <= r.sp;
        do @(posedge clk); while (!itm.ready);
        sb.note_request(r);
        while (gap < 20 && $urandom_range(99) < gap_pct)
            gap++;
        if (gap > 0)
        begin
            itm.valid <= 0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic request_t mk(logic [OP_W-1:0] op, logic [31:0] cnt);
        request_t r;
        r.op = op;
        r.cnt = cnt;
        r.run = ($urandom_range(99) < 92);
        r.flt = ($urandom_range(99) < 6);
        r.slow = ($urandom_range(99) < 20);
        r.plen = 24'($urandom);
        r.idx = 4'($urandom);
        r.st = 24'($urandom);
        r.en = 24'($urandom);
        r.sp = 24'($urandom);
        return r;
    endfunction

    function automatic request_t mk_load(logic [3:0] idx, logic [23:0] st, logic [23:0] en,
                                         logic [23:0] sp);
        request_t r;
        r = mk(OP_LOAD, $urandom);
        r.idx = idx;
        r.st = st;
        r.en = en;
        r.sp = sp;
        return r;
    endfunction

    // Waits until the block has drained so that registers may be changed.
    task automatic drain();
        itm.valid <= 0;
        while (sb.due_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic random_request();
        request_t r;
        int pick;
        logic [23:0] st;
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            if ($urandom_range(99) < 8)
                enc_now = enc_now + $urandom_range(1 << 20);
            else
                enc_now = enc_now + $urandom_range(3000);
            r = mk(OP_TICK, ($urandom_range(99) < 5) ? $urandom : enc_now);
            send(r);
        end
        else if (pick < 63)
        begin
            r = mk(OP_LEAD, enc_now);
            send(r);
        end
        else if (pick < 68)
        begin
            // A full calibration pass: arm, leading edge, trailing edge.
            r = mk(OP_ARM, $urandom);
            if ($urandom_range(99) < 85)
                r.plen = 24'($urandom_range(100 * 256, 500 * 256));
            send(r);
            send(mk(OP_LEAD, enc_now));
            enc_now = enc_now + $urandom_range(8000);
            send(mk(OP_TRAIL, ($urandom_range(99) < 10) ? $urandom : enc_now));
        end
        else if (pick < 71)
            send(mk(OP_ABORT, $urandom));
        else if (pick < 82)
        begin
            if ($urandom_range(99) < 12)
                send(mk(OP_LOAD, $urandom));
            else
            begin
                st = 24'($urandom_range(300 * 256));
                send(mk_load(4'($urandom), st, 24'(st + $urandom_range(200 * 256)),
                             24'($urandom_range(5 * 256, 100 * 256))));
            end
        end
        else if (pick < 86)
            send(mk(($urandom_range(1) != 0) ? OP_SPARE_HI : OP_SPARE_LO, $urandom));
        else
            send(mk(OP_TRAIL, $urandom));
    endtask

    initial
    begin
        request_t r;
        int ph;
        logic [31:0] pat_set [5];
        logic [31:0] cnt_set [5];
        logic [31:0] ppm_set [5];
        logic [31:0] off_set [5];
        int gap_set [4];
        int stall_set [4];

        sb = new();
        gap_set = '{0, 67, 0, 18};
        stall_set = '{0, 0, 67, 18};
        pat_set = '{1, 2, 3, 0, 2};
        cnt_set = '{16, 31, 1, 5, 16};
        ppm_set = '{808714, 32'hFFFFFFFF, 0, $urandom, 808714};
        off_set = '{64000, 0, MM_MAX, $urandom, 64000};
        gap_pct = 0;
        stall_pct = 0;
        hold_off = 0;
        enc_now = $urandom;
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        itm.valid = 0;
        itm.op = OP_TICK;
        itm.pulse_count = 0;
        itm.running = 0;
        itm.fault = 0;
        itm.too_slow = 0;
        itm.paper_length_mm = 0;
        itm.elem_index = 0;
        itm.elem_start_mm = 0;
        itm.elem_end_mm = 0;
        itm.elem_spacing_mm = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        apb_write(REG_PATTERN, 2);
        apb_write(REG_ECOUNT, 16);
        apb_write(REG_PPM, RATIO_RESET);
        apb_write(REG_OFFSET, OFFSET_RESET);

        // Every table entry is loaded before any sheet can read it.
        for (int i = 0; i < 14; i++)
            send(mk_load(4'(i), 24'(i * 20 * 256), 24'(i * 20 * 256 + 40 * 256), 24'(10 * 256)));
        send(mk_load(4'd14, 24'(200 * 256), 24'(100 * 256), 24'(10 * 256)));
        send(mk_load(4'd15, MM_MAX, MM_MAX, MM_MAX));

        // Calibration with zero length, then a real one.
        r = mk(OP_ARM, 0);
        r.plen = 0;
        send(r);
        send(mk(OP_LEAD, enc_now));
        send(mk(OP_TRAIL, enc_now + 5000));
        send(mk(OP_TRAIL, enc_now + 5000));
        r.plen = MM_MAX;
        send(r);
        send(mk(OP_LEAD, 0));
        send(mk(OP_TRAIL, 32'hFFFFFFFF));
        drain();
        apb_write(REG_PPM, RATIO_RESET);

        r = mk(OP_LEAD, enc_now);
        r.run = 0;
        send(r);
        r.run = 1;
        r.flt = 1;
        send(r);
        r.flt = 0;
        repeat (5) send(r);
        r = mk(OP_TICK, enc_now + 20000);
        r.run = 0;
        send(r);
        r.run = 1;
        r.slow = 1;
        send(r);
        r.slow = 0;
        send(r);
        send(mk(OP_SPARE_LO, 0));
        send(mk(OP_SPARE_HI, 32'hFFFFFFFF));
        send(mk(OP_ABORT, 0));
        // Zero spacing keeps repeating the same dot until the queue is aborted.
        send(mk_load(4'd2, 24'(30 * 256), 24'(60 * 256), 24'd0));
        r = mk(OP_LEAD, enc_now);
        r.run = 1;
        r.flt = 0;
        send(r);
        r = mk(OP_TICK, enc_now + 30000);
        r.run = 1;
        send(r);
        send(r);
        send(mk(OP_ABORT, 0));
        send(mk_load(4'd2, 24'(40 * 256), 24'(80 * 256), 24'(10 * 256)));

        for (ph = 0; ph < 5; ph++)
        begin
            drain();
            apb_write(REG_PATTERN, pat_set[ph]);
            apb_write(REG_ECOUNT, cnt_set[ph]);
            apb_write(REG_PPM, ppm_set[ph]);
            apb_write(REG_OFFSET, off_set[ph]);
            gap_pct = gap_set[ph % 4];
            stall_pct = stall_set[ph % 4];
            for (int k = 0; k < 30; k++)
            begin
                if (ph == 0 && k == 20)
                begin
                    // Receiver holds off while leading edges and ticks keep coming.
                    hold_off = 400;
                    for (int j = 0; j < 12; j++)
                    begin
                        r = mk(OP_LEAD, enc_now);
                        r.run = 1;
                        r.flt = 0;
                        send(r);
                        enc_now = enc_now + 2000;
                        r = mk(OP_TICK, enc_now);
                        r.run = 1;
                        send(r);
                    end
                end
                if (ph == 1 && k == 20)
                begin
                    itm.valid <= 0;
                    while (sb.due_q.size() != 0)
                        @(posedge clk);
                end
                random_request();
            end
        end

        drain();
        if (sb.errors == 0)
            $display("PASS encoder_pattern_event_scheduler");
        else
            $display("FAIL encoder_pattern_event_scheduler");
        $finish;
    end
endmodule
